// File: src/ppr_pkg.sv
`default_nettype none

package ppr_pkg;

    // Largest reassembled message, in bytes; a continuation may not pass it.
    localparam int unsigned MAX_MESSAGE = 256;

    localparam logic [3:0] PKT_LAST  = 4'd15;
    localparam logic [3:0] KIND_START = 4'd2;
    localparam logic [3:0] KIND_CONT  = 4'd3;
    localparam logic [7:0] START_MAX  = 8'd12;
    localparam logic [7:0] CONT_MAX   = 8'd15;
    localparam logic [7:0] SHORT_LEN  = 8'd2;

    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_COMPLETE   = 2'd1,
        ST_OVERSIZE   = 2'd2,
        ST_UNKNOWN    = 2'd3
    } t_status;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_offset;
        logic       packet_done;
        logic [3:0] msg_type;
        logic [7:0] msg_subtype;
        logic [7:0] msg_len;
        logic [7:0] msg_pad;
        t_status    status;
    } t_result;

    function automatic logic kind_is_short(input logic [3:0] kind);
        return (kind == 4'd0) || (kind == 4'd1) || (kind == 4'd4) ||
               (kind == 4'd6) || (kind == 4'd7);
    endfunction

endpackage

`default_nettype wire

// File: src/ppr_core.sv
`default_nettype none

module ppr_core
    import ppr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_pkt_byte,
    output t_result         o_result
);

    logic [3:0] r_pos, n_pos;
    logic [3:0] r_kind, n_kind;
    logic [7:0] r_len, n_len;
    logic [7:0] r_sub, n_sub;
    logic [7:0] r_pad, n_pad;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] r_part_sub, n_part_sub;
    logic [7:0] r_part_len, n_part_len;
    logic [7:0] r_part_pos, n_part_pos;
    logic       r_ovf, n_ovf;

    logic [7:0] rem;
    logic [7:0] cont_cnt;
    logic [8:0] cont_end;
    logic       ovf_start;
    logic [7:0] pos8;
    logic [7:0] cont_pos;
    t_result    res;

    // continuation budget, taken from the saved message at byte 0
    assign rem       = (r_part_len > r_part_pos) ? (r_part_len - r_part_pos) : 8'd0;
    assign cont_cnt  = (rem < CONT_MAX) ? rem : CONT_MAX;
    assign cont_end  = {1'b0, r_part_pos} + {1'b0, cont_cnt};
    assign ovf_start = (cont_cnt != 8'd0) && (cont_end > 9'(MAX_MESSAGE));
    assign pos8      = {4'd0, r_pos};
    assign cont_pos  = r_part_pos + n_cnt;

    always_comb begin
        n_pos      = 4'(r_pos + 4'd1);
        n_kind     = r_kind;
        n_len      = r_len;
        n_sub      = r_sub;
        n_pad      = r_pad;
        n_cnt      = r_cnt;
        n_part_sub = r_part_sub;
        n_part_len = r_part_len;
        n_part_pos = r_part_pos;
        n_ovf      = r_ovf;
        res        = '0;

        if (r_pos == 4'd0) begin
            n_kind = i_pkt_byte[3:0];
            n_cnt  = (i_pkt_byte[3:0] == KIND_CONT) ? cont_cnt : 8'd0;
            n_ovf  = (i_pkt_byte[3:0] == KIND_CONT) && ovf_start;
            n_pad  = 8'd0;
            n_len  = 8'd0;
            n_sub  = 8'd0;
        end

        if (kind_is_short(n_kind)) begin
            if (r_pos == 4'd1) begin
                n_pad = i_pkt_byte;
            end
            if (r_pos != PKT_LAST) begin
                res.payload_valid  = 1'b1;
                res.payload_byte   = i_pkt_byte;
                res.payload_offset = pos8;
            end
        end else if (n_kind == KIND_START) begin
            if (r_pos == 4'd1) begin
                n_len = (i_pkt_byte == 8'd0) ? 8'd0 : 8'(i_pkt_byte - 8'd1);
                n_cnt = (n_len < START_MAX) ? n_len : START_MAX;
            end else if (r_pos == 4'd3) begin
                n_sub = i_pkt_byte;
            end else if ((r_pos >= 4'd4) && (8'(pos8 - 8'd4) < n_cnt)) begin
                res.payload_valid  = 1'b1;
                res.payload_byte   = i_pkt_byte;
                res.payload_offset = 8'(pos8 - 8'd4);
            end
        end else if (n_kind == KIND_CONT) begin
            if (!n_ovf && (r_pos >= 4'd1) && (8'(pos8 - 8'd1) < n_cnt)) begin
                res.payload_valid  = 1'b1;
                res.payload_byte   = i_pkt_byte;
                res.payload_offset = 8'(r_part_pos + pos8 - 8'd1);
            end
        end

        if (r_pos == PKT_LAST) begin
            res.packet_done = 1'b1;
            res.msg_type    = n_kind;
            if (kind_is_short(n_kind)) begin
                res.msg_len = SHORT_LEN;
                res.msg_pad = n_pad;
                res.status  = ST_COMPLETE;
            end else if (n_kind == KIND_START) begin
                res.msg_subtype = n_sub;
                res.msg_len     = n_len;
                if (n_cnt < n_len) begin
                    // open message: remember it for the continuations
                    n_part_sub = n_sub;
                    n_part_len = n_len;
                    n_part_pos = n_cnt;
                    res.status = ST_INCOMPLETE;
                end else begin
                    res.status = ST_COMPLETE;
                end
            end else if (n_kind == KIND_CONT) begin
                res.msg_type    = KIND_START;
                res.msg_subtype = r_part_sub;
                res.msg_len     = r_part_len;
                if (n_ovf) begin
                    res.status = ST_OVERSIZE;
                end else begin
                    n_part_pos = cont_pos;
                    res.status = (cont_pos < r_part_len) ? ST_INCOMPLETE : ST_COMPLETE;
                end
            end else begin
                res.status = ST_UNKNOWN;
            end
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_kind     <= '0;
            r_len      <= '0;
            r_sub      <= '0;
            r_pad      <= '0;
            r_cnt      <= '0;
            r_part_sub <= '0;
            r_part_len <= '0;
            r_part_pos <= '0;
            r_ovf      <= 1'b0;
        end else if (i_en) begin
            r_pos      <= n_pos;
            r_kind     <= n_kind;
            r_len      <= n_len;
            r_sub      <= n_sub;
            r_pad      <= n_pad;
            r_cnt      <= n_cnt;
            r_part_sub <= n_part_sub;
            r_part_len <= n_part_len;
            r_part_pos <= n_part_pos;
            r_ovf      <= n_ovf;
        end
    end

endmodule

`default_nettype wire

// File: src/ppr_outbuf.sv
`default_nettype none

module ppr_outbuf
    import ppr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_result i_data,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    logic    r_valid;
    t_result r_data;

    // free when empty or when the held item leaves this cycle
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// File: src/phone_packet_reassembler.sv
`default_nettype none

// Channel  Direction  Handshake                   Payload
// in       input      i_in_valid / o_in_ready     i_pkt_byte
// out      output     o_out_valid / i_out_ready   o_payload_*, o_packet_done, o_msg_*, o_status
//
// One item in, one item out. Each byte is decoded against the packet state
// in the cycle it is accepted and is then held in the output register; a
// new byte is taken every cycle unless the output stalls. The rate is set
// by the state update in ppr_core, which has to finish before the next byte.
// Reset (i_rst_n low, synchronous) clears the byte position, the saved
// message and the output valid. A stalled output holds its item; the input
// is still taken in the same cycle the held item is drained.

module phone_packet_reassembler
    import ppr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_pkt_byte,

    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_payload_valid,
    output logic [7:0]      o_payload_byte,
    output logic [7:0]      o_payload_offset,
    output logic            o_packet_done,
    output logic [3:0]      o_msg_type,
    output logic [7:0]      o_msg_subtype,
    output logic [7:0]      o_msg_len,
    output logic [7:0]      o_msg_pad,
    output logic [1:0]      o_status
);

    t_result step_res;
    t_result out_res;
    logic    accept;

    assign accept = i_in_valid && o_in_ready;

    // packet state and per-byte decode
    ppr_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (accept),
        .i_pkt_byte (i_pkt_byte),
        .o_result   (step_res)
    );

    // result register, decouples the output stall from the input side
    ppr_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (step_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_res)
    );

    assign o_payload_valid  = out_res.payload_valid;
    assign o_payload_byte   = out_res.payload_byte;
    assign o_payload_offset = out_res.payload_offset;
    assign o_packet_done    = out_res.packet_done;
    assign o_msg_type       = out_res.msg_type;
    assign o_msg_subtype    = out_res.msg_subtype;
    assign o_msg_len        = out_res.msg_len;
    assign o_msg_pad        = out_res.msg_pad;
    assign o_status         = 2'(out_res.status);

    // input can only be blocked by a held result
    a_ready_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid
    ) else $error("input stalled with empty output register");

    // status fields are zero except on the last byte of a packet
    a_status_only_on_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_packet_done) |->
            (o_status == 2'(ST_INCOMPLETE)) && (o_msg_len == 8'd0) && (o_msg_type == 4'd0)
    ) else $error("status reported on a non-final byte");

    // an oversize or unknown packet never carries payload
    a_no_payload_on_error: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_packet_done &&
         ((o_status == 2'(ST_OVERSIZE)) || (o_status == 2'(ST_UNKNOWN)))) |->
            !o_payload_valid
    ) else $error("payload given on an error packet");

    // a result taken with nothing behind it leaves the register empty
    a_drain_empties: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !i_in_valid) |=> !o_out_valid
    ) else $error("output register did not drain");

endmodule

`default_nettype wire

// File: verif/phone_packet_reassembler_test.sv
`timescale 1ns / 1ps

module phone_packet_reassembler_test
    import ppr_pkg::*;
();

    localparam int unsigned CLK_PERIOD  = 10;
    localparam int unsigned RESET_CYCLES = 5;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD   = 300;   // receiver back-pressure stretch
    localparam int unsigned DRAIN_WAIT  = 10;    // settle time after the last report
    localparam int unsigned MAX_REPORTED = 10;

    // Kind classes, one bit per low-nibble value of packet byte 0.
    localparam logic [15:0] SHORT_KIND_MASK   = 16'h00D3;  // 0,1,4,6,7
    localparam logic [15:0] UNKNOWN_KIND_MASK = 16'hFF20;  // 5, 8..15

    // Byte positions inside a packet.
    localparam logic [3:0] POS_HEADER     = 4'd0;
    localparam logic [3:0] POS_LEN        = 4'd1;
    localparam logic [3:0] POS_SUBTYPE    = 4'd3;
    localparam logic [3:0] POS_START_DATA = 4'd4;
    localparam int unsigned PKT_BYTES     = 16;

    typedef enum int unsigned {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } t_fill;

    // DUT connections; every input starts known.
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_pkt_byte = 8'd0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_payload_valid;
    logic [7:0] o_payload_byte;
    logic [7:0] o_payload_offset;
    logic       o_packet_done;
    logic [3:0] o_msg_type;
    logic [7:0] o_msg_subtype;
    logic [7:0] o_msg_len;
    logic [7:0] o_msg_pad;
    logic [1:0] o_status;

    phone_packet_reassembler u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pkt_byte      (i_pkt_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_payload_offset(o_payload_offset),
        .o_packet_done   (o_packet_done),
        .o_msg_type      (o_msg_type),
        .o_msg_subtype   (o_msg_subtype),
        .o_msg_len       (o_msg_len),
        .o_msg_pad       (o_msg_pad),
        .o_status        (o_status)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Stream bookkeeping shared by the stimulus, driver and checker
    // ------------------------------------------------------------------
    logic [7:0]  pkt_bytes_q [$];   // bytes waiting to be offered
    t_result     report_q [$];      // predicted reports, oldest first

    int unsigned bytes_queued    = 0;
    int unsigned packets_queued  = 0;
    int unsigned tx_idle_max     = 3;
    int unsigned rx_idle_max     = 3;
    int unsigned tx_gap          = 0;
    int unsigned rx_wait         = 0;
    int unsigned hold_left       = 0;
    int unsigned holds_asked     = 0;
    int unsigned holds_served    = 0;
    int unsigned cycle_count     = 0;
    int unsigned mismatch_count  = 0;
    int unsigned results_seen    = 0;
    int unsigned payload_seen    = 0;
    int unsigned done_complete   = 0;
    int unsigned done_incomplete = 0;
    int unsigned done_unknown    = 0;

    // ------------------------------------------------------------------
    // Reassembly predictor: packet state of the stream as seen so far
    // ------------------------------------------------------------------
    logic [3:0] pkt_pos       = '0;   // position of the next byte in its packet
    logic [3:0] pkt_kind      = '0;
    logic [7:0] pkt_len       = '0;   // declared length of a start packet
    logic [7:0] pkt_subtype   = '0;
    logic [7:0] pkt_pad       = '0;
    logic [7:0] pkt_count     = '0;   // payload bytes this packet carries
    logic       pkt_oversize  = 1'b0;
    logic [7:0] saved_subtype = '0;   // unfinished message carried across packets
    logic [7:0] saved_len     = '0;
    logic [7:0] saved_pos     = '0;

    task automatic reassemble_byte(input logic [7:0] b, output t_result r);
        int unsigned remain;
        int unsigned take;
        logic        short_kind;
        r = '0;
        if (pkt_pos == POS_HEADER) begin
            pkt_kind     = b[3:0];
            pkt_count    = '0;
            pkt_oversize = 1'b0;
            pkt_pad      = '0;
            pkt_len      = '0;
            pkt_subtype  = '0;
            if (pkt_kind == KIND_CONT) begin
                remain = (saved_len > saved_pos) ? saved_len - saved_pos : 0;
                take   = (remain < CONT_MAX) ? remain : CONT_MAX;
                pkt_count = take[7:0];
                // Can only trip when MAX_MESSAGE is below the 254-byte length ceiling.
                if (take > 0 && saved_pos + take > MAX_MESSAGE)
                    pkt_oversize = 1'b1;
            end
        end
        short_kind = SHORT_KIND_MASK[pkt_kind];

        if (short_kind) begin
            if (pkt_pos == POS_LEN)
                pkt_pad = b;
            if (pkt_pos != PKT_LAST) begin
                r.payload_valid  = 1'b1;
                r.payload_byte   = b;
                r.payload_offset = {4'd0, pkt_pos};
            end
        end else if (pkt_kind == KIND_START) begin
            if (pkt_pos == POS_LEN) begin
                // a zero length byte means length zero, not 255
                pkt_len   = (b == 8'd0) ? 8'd0 : b - 8'd1;
                pkt_count = (pkt_len < START_MAX) ? pkt_len : START_MAX;
            end else if (pkt_pos == POS_SUBTYPE) begin
                pkt_subtype = b;
            end else if (pkt_pos >= POS_START_DATA &&
                         ({4'd0, pkt_pos} - {4'd0, POS_START_DATA}) < pkt_count) begin
                r.payload_valid  = 1'b1;
                r.payload_byte   = b;
                r.payload_offset = {4'd0, pkt_pos} - {4'd0, POS_START_DATA};
            end
        end else if (pkt_kind == KIND_CONT) begin
            if (!pkt_oversize && pkt_pos >= POS_LEN &&
                ({4'd0, pkt_pos} - 8'd1) < pkt_count) begin
                r.payload_valid  = 1'b1;
                r.payload_byte   = b;
                r.payload_offset = saved_pos + {4'd0, pkt_pos} - 8'd1;
            end
        end

        if (pkt_pos == PKT_LAST) begin
            r.packet_done = 1'b1;
            r.msg_type    = pkt_kind;
            if (short_kind) begin
                r.msg_len = SHORT_LEN;
                r.msg_pad = pkt_pad;
                r.status  = ST_COMPLETE;
            end else if (pkt_kind == KIND_START) begin
                r.msg_subtype = pkt_subtype;
                r.msg_len     = pkt_len;
                if (pkt_count < pkt_len) begin
                    saved_subtype = pkt_subtype;
                    saved_len     = pkt_len;
                    saved_pos     = pkt_count;
                    r.status      = ST_INCOMPLETE;
                end else begin
                    // complete in one packet: the saved message stays as it was
                    r.status = ST_COMPLETE;
                end
            end else if (pkt_kind == KIND_CONT) begin
                // continuations always report as the saved start message
                r.msg_type = KIND_START;
                if (pkt_oversize) begin
                    r.status = ST_OVERSIZE;
                end else begin
                    saved_pos = saved_pos + pkt_count;
                    r.status  = (saved_pos < saved_len) ? ST_INCOMPLETE : ST_COMPLETE;
                end
                r.msg_subtype = saved_subtype;
                r.msg_len     = saved_len;
            end else begin
                r.status = ST_UNKNOWN;
            end
            pkt_pos = '0;
        end else begin
            pkt_pos = pkt_pos + 4'd1;
        end
    endtask

    // ------------------------------------------------------------------
    // Packet builders
    // ------------------------------------------------------------------
    function automatic logic [7:0] header_for(input logic [3:0] kind);
        logic [3:0] upper;
        upper = 4'($urandom_range(0, 15));
        return {upper, kind};
    endfunction

    function automatic logic [3:0] pick_kind(input logic [15:0] kind_mask);
        logic [3:0] k;
        do
            k = 4'($urandom_range(0, 15));
        while (!kind_mask[k]);
        return k;
    endfunction

    // Mostly short messages, a few long ones up to the 254-byte ceiling.
    function automatic logic [7:0] pick_len_byte();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 75)
            return 8'($urandom_range(0, 30));
        else if (sel < 93)
            return 8'($urandom_range(31, 120));
        else
            return 8'($urandom_range(200, 255));
    endfunction

    task automatic queue_packet(input logic [7:0] hdr, input logic [7:0] len_byte,
                                input logic [7:0] sub_byte, input t_fill fill);
        logic [7:0] fb;
        pkt_bytes_q.push_back(hdr);
        pkt_bytes_q.push_back(len_byte);
        for (int i = 2; i < PKT_BYTES; i++) begin
            case (fill)
                FILL_ZERO: fb = 8'h00;
                FILL_ONES: fb = 8'hff;
                default:   fb = 8'($urandom);
            endcase
            pkt_bytes_q.push_back((i == POS_SUBTYPE) ? sub_byte : fb);
        end
        bytes_queued   += PKT_BYTES;
        packets_queued += 1;
    endtask

    // A start packet and the continuations it needs, now and then cut short,
    // interleaved with a short packet, or followed by one continuation too many.
    task automatic queue_message(input logic [7:0] len_byte);
        int unsigned len;
        int unsigned left;
        int unsigned conts;
        len   = (len_byte == 8'd0) ? 0 : len_byte - 1;
        left  = (len > START_MAX) ? len - START_MAX : 0;
        conts = (left + CONT_MAX - 1) / CONT_MAX;
        queue_packet(header_for(KIND_START), len_byte, 8'($urandom), FILL_RANDOM);
        for (int c = 0; c < conts; c++) begin
            if ($urandom_range(0, 19) == 0)
                return;
            if ($urandom_range(0, 9) == 0)
                queue_packet(header_for(pick_kind(SHORT_KIND_MASK)), 8'($urandom),
                             8'($urandom), FILL_RANDOM);
            queue_packet(header_for(KIND_CONT), 8'($urandom), 8'($urandom), FILL_RANDOM);
        end
        if ($urandom_range(0, 9) == 0)
            queue_packet(header_for(KIND_CONT), 8'($urandom), 8'($urandom), FILL_RANDOM);
    endtask

    task automatic queue_random_traffic(input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned sel;
        stop_at = bytes_queued + n_bytes;
        while (bytes_queued < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
                queue_message(pick_len_byte());
            else if (sel < 72)
                queue_packet(header_for(pick_kind(SHORT_KIND_MASK)), 8'($urandom),
                             8'($urandom), FILL_RANDOM);
            else if (sel < 80)
                queue_packet(header_for(pick_kind(UNKNOWN_KIND_MASK)), 8'($urandom),
                             8'($urandom), FILL_RANDOM);
            else if (sel < 88)
                queue_packet(header_for(KIND_CONT), 8'($urandom), 8'($urandom),
                             FILL_RANDOM);
            else
                queue_packet(8'($urandom), 8'($urandom), 8'($urandom), FILL_RANDOM);
        end
    endtask

    // Sender and block both idle, and every predicted report has arrived.
    task automatic wait_stream_quiet();
        while (pkt_bytes_q.size() != 0 || i_in_valid || report_q.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Byte driver: offers queued bytes, predicts each one on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : byte_driver
        t_result want;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap     <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                reassemble_byte(i_pkt_byte, want);
                report_q.push_back(want);
            end
            if (i_in_valid && !o_in_ready) begin
                // item still pending: keep valid and payload as they are
            end else if (tx_gap != 0) begin
                tx_gap     <= tx_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pkt_bytes_q.size() != 0) begin
                i_in_valid <= 1'b1;
                i_pkt_byte <= pkt_bytes_q.pop_front();
                tx_gap     <= $urandom_range(0, tx_idle_max);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Report sink: random per-item stalls plus requested long holds
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : report_sink
        int unsigned draw;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_wait     <= 0;
            hold_left   <= 0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
            i_out_ready  <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait     <= rx_wait - 1;
            i_out_ready <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            draw        = $urandom_range(0, rx_idle_max);
            rx_wait     <= (draw == 0) ? 0 : draw - 1;
            i_out_ready <= (draw == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Report checker
    // ------------------------------------------------------------------
    task automatic check_field(input int unsigned idx, input string field,
                               input logic [7:0] got, input logic [7:0] want);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
                $display("Mismatch in report %0d, %s: expected %02h, got %02h",
                         idx, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : report_check
        t_result want;
        t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.payload_valid  = o_payload_valid;
            got.payload_byte   = o_payload_byte;
            got.payload_offset = o_payload_offset;
            got.packet_done    = o_packet_done;
            got.msg_type       = o_msg_type;
            got.msg_subtype    = o_msg_subtype;
            got.msg_len        = o_msg_len;
            got.msg_pad        = o_msg_pad;
            got.status         = t_status'(o_status);
            if (report_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTED)
                    $display("Unexpected report %0d with nothing predicted", results_seen);
            end else begin
                want = report_q.pop_front();
                check_field(results_seen, "payload_valid",  got.payload_valid,  want.payload_valid);
                check_field(results_seen, "payload_byte",   got.payload_byte,   want.payload_byte);
                check_field(results_seen, "payload_offset", got.payload_offset,
                            want.payload_offset);
                check_field(results_seen, "packet_done",    got.packet_done,    want.packet_done);
                check_field(results_seen, "msg_type",       got.msg_type,       want.msg_type);
                check_field(results_seen, "msg_subtype",    got.msg_subtype,    want.msg_subtype);
                check_field(results_seen, "msg_len",        got.msg_len,        want.msg_len);
                check_field(results_seen, "msg_pad",        got.msg_pad,        want.msg_pad);
                check_field(results_seen, "status",         got.status,         want.status);
            end
            results_seen++;
            if (o_payload_valid === 1'b1)
                payload_seen++;
            if (o_packet_done === 1'b1) begin
                case (t_status'(o_status))
                    ST_COMPLETE:   done_complete++;
                    ST_INCOMPLETE: done_incomplete++;
                    ST_UNKNOWN:    done_unknown++;
                    default:       ;
                endcase
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reports still predicted",
                     cycle_count, report_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed packets.
        // Continuation before any start: reports the empty reset message, complete.
        queue_packet(8'h03, 8'($urandom), 8'($urandom), FILL_RANDOM);
        // Short packets of every short kind, with all-zero and all-one contents.
        queue_packet(8'h00, 8'h00, 8'h00, FILL_ZERO);
        queue_packet(8'hF7, 8'hFF, 8'hFF, FILL_ONES);
        queue_packet(header_for(4'd1), 8'($urandom), 8'($urandom), FILL_RANDOM);
        queue_packet(header_for(4'd4), 8'($urandom), 8'($urandom), FILL_RANDOM);
        queue_packet(header_for(4'd6), 8'($urandom), 8'($urandom), FILL_RANDOM);
        // Zero length byte, then a length that exactly fills a start packet.
        queue_packet(8'h02, 8'h00, 8'h00, FILL_ZERO);
        queue_packet(header_for(KIND_START), 8'd13, 8'($urandom), FILL_RANDOM);
        // Unknown kinds.
        queue_packet(8'h05, 8'($urandom), 8'($urandom), FILL_RANDOM);
        queue_packet(8'hFF, 8'hFF, 8'hFF, FILL_ONES);
        // Longest message, with foreign packets in between and a continuation
        // past its end.
        queue_packet(8'hF2, 8'hFF, 8'hFF, FILL_ONES);
        for (int c = 0; c < 17; c++) begin
            if (c == 3)
                queue_packet(8'hF8, 8'($urandom), 8'($urandom), FILL_RANDOM);
            if (c == 9)
                queue_packet(header_for(4'd4), 8'($urandom), 8'($urandom), FILL_RANDOM);
            queue_packet(header_for(KIND_CONT), 8'($urandom), 8'($urandom), FILL_RANDOM);
        end
        queue_packet(8'hF3, 8'($urandom), 8'($urandom), FILL_RANDOM);

        // Random traffic, first part.
        queue_random_traffic(60);

        // Sender pauses until the block has delivered everything.
        wait_stream_quiet();

        // Long receiver hold while the sender keeps offering bytes.
        holds_asked++;
        queue_random_traffic(60);
        wait_stream_quiet();

        // A stretch without any idling on either side, then idling again.
        tx_idle_max = 0;
        rx_idle_max = 0;
        queue_random_traffic(30);
        wait_stream_quiet();
        tx_idle_max = 3;
        rx_idle_max = 3;
        queue_random_traffic(30);

        wait_stream_quiet();
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("Sent %0d bytes in %0d packets; checked %0d reports, %0d payload bytes",
                 bytes_queued, packets_queued, results_seen, payload_seen);
        $display("Packet ends: %0d complete, %0d incomplete, %0d unknown kind; %0d mismatches",
                 done_complete, done_incomplete, done_unknown, mismatch_count);
        if (mismatch_count == 0 && report_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
src/ppr_pkg.sv
src/ppr_core.sv
src/ppr_outbuf.sv
src/phone_packet_reassembler.sv
verif/phone_packet_reassembler_test.sv
